// File: sv/v3a_pkg.sv
// ---------------------------------------------------------------------------
// v3a_pkg
// Operation codes shared by the vector ALU modules.
// ---------------------------------------------------------------------------
`default_nettype none
package v3a_pkg;
  localparam int FUNC_W = 3;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SCL  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LEN  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NORM = 3'd4;
endpackage
`default_nettype wire

// File: sv/v3a_front_lane.sv
// ---------------------------------------------------------------------------
// v3a_front_lane
// One component lane: add, subtract and scale with saturation, plus the
// square and magnitude of the A component for the length path. Two stages.
// ---------------------------------------------------------------------------
`default_nettype none
module v3a_front_lane
  import v3a_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire [FUNC_W-1:0]             func_i,
  input  wire signed [COORD_WIDTH-1:0] a_i,
  input  wire signed [COORD_WIDTH-1:0] b_i,
  input  wire signed [COORD_WIDTH-1:0] k_i,
  output logic [COORD_WIDTH-1:0]       res_o,
  output logic                         sat_o,
  output logic [2*COORD_WIDTH-1:0]     sq_o,
  output logic [COORD_WIDTH-1:0]       mag_o,
  output logic                         neg_o
);
  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * COORD_WIDTH;

  logic [W-1:0]  ma, mk;
  logic [FUNC_W-1:0] func_r;
  logic signed [W:0] sum_r;
  logic [PW-1:0] prod_r, sq_r;
  logic          negk_r, nega_r;
  logic [W-1:0]  ma_r;

  logic [PW-1:0] rnd, lim, clv;
  logic [W-1:0]  res_nxt;
  logic          sat_nxt;

  assign ma = a_i[W-1] ? W'(-a_i) : W'(a_i);
  assign mk = k_i[W-1] ? W'(-k_i) : W'(k_i);

  always_ff @(posedge clk) begin
    func_r <= func_i;
    if (func_i == FUNC_SUB) begin
      sum_r <= (W+1)'(a_i) - (W+1)'(b_i);
    end else begin
      sum_r <= (W+1)'(a_i) + (W+1)'(b_i);
    end
    prod_r <= PW'(ma) * PW'(mk);
    sq_r   <= PW'(ma) * PW'(ma);
    negk_r <= a_i[W-1] ^ k_i[W-1];
    nega_r <= a_i[W-1];
    ma_r   <= ma;
  end

  always_comb begin
    rnd = (prod_r + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = negk_r ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
    clv = (rnd > lim) ? lim : rnd;
    res_nxt = '0;
    sat_nxt = 1'b0;
    unique case (func_r)
      FUNC_ADD, FUNC_SUB: begin
        if (sum_r[W] != sum_r[W-1]) begin
          sat_nxt = 1'b1;
          res_nxt = sum_r[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
          res_nxt = sum_r[W-1:0];
        end
      end
      FUNC_SCL: begin
        sat_nxt = rnd > lim;
        res_nxt = negk_r ? W'(-clv[W-1:0]) : clv[W-1:0];
      end
      default: begin
        res_nxt = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_o <= res_nxt;
    sat_o <= sat_nxt;
    sq_o  <= sq_r;
    mag_o <= ma_r;
    neg_o <= nega_r;
  end
endmodule
`default_nettype wire

// File: sv/v3a_sqrt.sv
// ---------------------------------------------------------------------------
// v3a_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, followed by
// a rounding stage that gives the root rounded to nearest.
// ---------------------------------------------------------------------------
`default_nettype none
module v3a_sqrt #(
  parameter int COORD_WIDTH = 32
) (
  input  wire                        clk,
  input  wire [2*COORD_WIDTH-1:0]    n_i,
  output logic [COORD_WIDTH:0]       len_o
);
  localparam int W = COORD_WIDTH;

  logic [W:0]     rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] nb_r   [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic [W:0]     rem_in;
    logic [W-1:0]   root_in;
    logic [2*W-1:0] nb_in;
    logic [W+2:0]   rem_sh, trial, diff;
    logic           ge;
    logic [W:0]     rem_nxt;
    logic [W-1:0]   root_nxt;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign nb_in   = n_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign nb_in   = nb_r[j-1];
    end

    always_comb begin
      rem_sh   = {rem_in, nb_in[2*W-1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = rem_sh >= trial;
      diff     = rem_sh - trial;
      rem_nxt  = ge ? diff[W:0] : rem_sh[W:0];
      root_nxt = {root_in[W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
      nb_r[j]   <= nb_in << 2;
    end
  end

  // The remainder is n - root^2; round up when it exceeds the root.
  always_ff @(posedge clk) begin
    len_o <= {1'b0, root_r[W-1]} + (W+1)'(rem_r[W-1] > {1'b0, root_r[W-1]});
  end
endmodule
`default_nettype wire

// File: sv/v3a_div.sv
// ---------------------------------------------------------------------------
// v3a_div
// Pipelined restoring divider for one lane: (m << FRAC_BITS) / d, rounded
// to nearest with ties away from zero, signed and clamped to the range.
// ---------------------------------------------------------------------------
`default_nettype none
module v3a_div #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                    clk,
  input  wire [COORD_WIDTH-1:0]  m_i,
  input  wire                    neg_i,
  input  wire [COORD_WIDTH:0]    d_i,
  output logic [COORD_WIDTH-1:0] res_o,
  output logic                   sat_o
);
  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NS = FRAC_BITS + 1;
  localparam int CW = COORD_WIDTH + FRAC_BITS + 2;

  // The magnitude never exceeds the divisor, so only F+1 quotient bits exist.
  logic [W:0] rem_r [NS];
  logic [F:0] q_r   [NS];
  logic [W:0] d_r   [NS];
  logic       neg_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [W:0]   rem_in, d_in;
    logic [F:0]   q_in;
    logic         neg_in, nbit, ge;
    logic [W+1:0] rem_sh, diff;
    logic [W:0]   rem_nxt;

    if (j == 0) begin : g_first
      assign rem_in = (W+1)'(m_i >> 1);
      assign q_in   = '0;
      assign d_in   = d_i;
      assign neg_in = neg_i;
      assign nbit   = m_i[0];
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign d_in   = d_r[j-1];
      assign neg_in = neg_r[j-1];
      assign nbit   = 1'b0;
    end

    always_comb begin
      rem_sh  = {rem_in, nbit};
      ge      = rem_sh >= {1'b0, d_in};
      diff    = rem_sh - {1'b0, d_in};
      rem_nxt = ge ? diff[W:0] : rem_sh[W:0];
    end

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      q_r[j]   <= {q_in[F-1:0], ge};
      d_r[j]   <= d_in;
      neg_r[j] <= neg_in;
    end
  end

  logic          up;
  logic [CW-1:0] qr, lim, clv;

  always_comb begin
    up  = rem_r[NS-1] >= (d_r[NS-1] - rem_r[NS-1]);
    qr  = CW'(q_r[NS-1]) + CW'(up);
    lim = neg_r[NS-1] ? (CW'(1) << (W - 1)) : ((CW'(1) << (W - 1)) - CW'(1));
    clv = (qr > lim) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    sat_o <= qr > lim;
    res_o <= neg_r[NS-1] ? W'(-clv[W-1:0]) : clv[W-1:0];
  end
endmodule
`default_nettype wire

// File: sv/vector3_alu.sv
// ---------------------------------------------------------------------------
// vector3_alu
// Three-lane fixed-point vector ALU: add, subtract, scale, length, normalize.
// ---------------------------------------------------------------------------
// Every operation takes the same path from start to out_valid
// (one root bit per sqrt stage, one quotient bit per divider stage).
// Throughput: one word per cycle; busy is always low.
// Reset clears the valid pipeline only; the receiver cannot stall.
`default_nettype none
module vector3_alu
  import v3a_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire [FUNC_W-1:0]             in_func,
  input  wire signed [COORD_WIDTH-1:0] in_ax,
  input  wire signed [COORD_WIDTH-1:0] in_ay,
  input  wire signed [COORD_WIDTH-1:0] in_az,
  input  wire signed [COORD_WIDTH-1:0] in_bx,
  input  wire signed [COORD_WIDTH-1:0] in_by,
  input  wire signed [COORD_WIDTH-1:0] in_bz,
  input  wire signed [COORD_WIDTH-1:0] in_scale_factor,
  output logic                         out_valid,
  output logic signed [COORD_WIDTH-1:0] out_rx,
  output logic signed [COORD_WIDTH-1:0] out_ry,
  output logic signed [COORD_WIDTH-1:0] out_rz,
  output logic [COORD_WIDTH-1:0]       out_length_out,
  output logic                         out_saturated,
  output logic                         out_zero_length
);
  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int NV    = W + F + 7;
  localparam int DSIDE = W + F + 4;
  localparam int DMAG  = W + 2;
  localparam int DLEN  = F + 2;
  localparam int SIDEW = FUNC_W + 3 * W + 1;
  localparam int MAGW  = 3 * (W + 1);

  assign busy = 1'b0;

  logic              vld_r [NV];
  logic [FUNC_W-1:0] func_r;
  logic signed [W-1:0] a_r [3], b_r [3];
  logic signed [W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= start;
      for (int i = 1; i < NV; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    func_r <= in_func;
    a_r[0] <= in_ax;
    a_r[1] <= in_ay;
    a_r[2] <= in_az;
    b_r[0] <= in_bx;
    b_r[1] <= in_by;
    b_r[2] <= in_bz;
    k_r    <= in_scale_factor;
  end

  // Front lanes.
  logic [W-1:0]   fres [3];
  logic           fsat [3];
  logic [2*W-1:0] fsq  [3];
  logic [W-1:0]   fmag [3];
  logic           fneg [3];
  logic [FUNC_W-1:0] func2_r, func1_r;

  for (genvar g = 0; g < 3; g++) begin : g_front
    v3a_front_lane #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_lane (
      .clk    (clk),
      .func_i (func_r),
      .a_i    (a_r[g]),
      .b_i    (b_r[g]),
      .k_i    (k_r),
      .res_o  (fres[g]),
      .sat_o  (fsat[g]),
      .sq_o   (fsq[g]),
      .mag_o  (fmag[g]),
      .neg_o  (fneg[g])
    );
  end

  always_ff @(posedge clk) begin
    func1_r <= func_r;
    func2_r <= func1_r;
  end

  // Sum of squares and root.
  logic [2*W-1:0] n_r;
  logic [W:0]     len_raw;

  always_ff @(posedge clk) begin
    n_r <= fsq[0] + fsq[1] + fsq[2];
  end

  v3a_sqrt #(.COORD_WIDTH(W)) u_sqrt (
    .clk   (clk),
    .n_i   (n_r),
    .len_o (len_raw)
  );

  // Delay lines that keep side data aligned with the slow path.
  logic [SIDEW-1:0] side_r [DSIDE];
  logic [MAGW-1:0]  mag_r  [DMAG];
  logic [W:0]       len_r  [DLEN];

  always_ff @(posedge clk) begin
    side_r[0] <= {func2_r, fres[0], fres[1], fres[2], fsat[0] | fsat[1] | fsat[2]};
    mag_r[0]  <= {fneg[0], fmag[0], fneg[1], fmag[1], fneg[2], fmag[2]};
    len_r[0]  <= len_raw;
    for (int i = 1; i < DSIDE; i++) side_r[i] <= side_r[i-1];
    for (int i = 1; i < DMAG; i++)  mag_r[i]  <= mag_r[i-1];
    for (int i = 1; i < DLEN; i++)  len_r[i]  <= len_r[i-1];
  end

  // Normalize lanes.
  logic [W:0]   dsr;
  logic [W-1:0] dres [3];
  logic         dsat [3];

  assign dsr = (len_raw == '0) ? (W+1)'(1) : len_raw;

  for (genvar g = 0; g < 3; g++) begin : g_div
    localparam int BASE = (2 - g) * (W + 1);
    v3a_div #(.COORD_WIDTH(W), .FRAC_BITS(F)) u_div (
      .clk   (clk),
      .m_i   (mag_r[DMAG-1][BASE +: W]),
      .neg_i (mag_r[DMAG-1][BASE + W]),
      .d_i   (dsr),
      .res_o (dres[g]),
      .sat_o (dsat[g])
    );
  end

  // Merge.
  logic [FUNC_W-1:0] sfunc;
  logic [W-1:0]      sres [3];
  logic              ssat, lsat, lzero;
  logic [W:0]        lfull;
  logic [W-1:0]      lclamp;
  logic [W-1:0]      rx_nxt, ry_nxt, rz_nxt, len_nxt;
  logic              sat_nxt, zero_nxt;

  always_comb begin
    sfunc   = side_r[DSIDE-1][SIDEW-1 -: FUNC_W];
    sres[0] = side_r[DSIDE-1][1 + 2*W +: W];
    sres[1] = side_r[DSIDE-1][1 + W +: W];
    sres[2] = side_r[DSIDE-1][1 +: W];
    ssat    = side_r[DSIDE-1][0];
    lfull   = len_r[DLEN-1];
    lzero   = lfull == '0;
    lsat    = lfull[W];
    lclamp  = lsat ? {W{1'b1}} : lfull[W-1:0];
    rx_nxt   = '0;
    ry_nxt   = '0;
    rz_nxt   = '0;
    len_nxt  = '0;
    sat_nxt  = 1'b0;
    zero_nxt = 1'b0;
    unique case (sfunc)
      FUNC_ADD, FUNC_SUB, FUNC_SCL: begin
        rx_nxt  = sres[0];
        ry_nxt  = sres[1];
        rz_nxt  = sres[2];
        sat_nxt = ssat;
      end
      FUNC_LEN: begin
        len_nxt = lclamp;
        sat_nxt = lsat;
      end
      FUNC_NORM: begin
        if (lzero) begin
          zero_nxt = 1'b1;
        end else begin
          rx_nxt  = dres[0];
          ry_nxt  = dres[1];
          rz_nxt  = dres[2];
          len_nxt = lclamp;
          sat_nxt = lsat | dsat[0] | dsat[1] | dsat[2];
        end
      end
      default: begin
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    out_rx          <= rx_nxt;
    out_ry          <= ry_nxt;
    out_rz          <= rz_nxt;
    out_length_out  <= len_nxt;
    out_saturated   <= sat_nxt;
    out_zero_length <= zero_nxt;
  end
endmodule
`default_nettype wire

// File: sv/v3a_checker.sv
// ---------------------------------------------------------------------------
// v3a_checker
// Port-level checks for the vector ALU, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
module v3a_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   start,
  input wire                   busy,
  input wire                   out_valid,
  input wire [COORD_WIDTH-1:0] out_rx,
  input wire [COORD_WIDTH-1:0] out_ry,
  input wire [COORD_WIDTH-1:0] out_rz,
  input wire [COORD_WIDTH-1:0] out_length_out,
  input wire                   out_saturated,
  input wire                   out_zero_length
);
  localparam int LAT = COORD_WIDTH + FRAC_BITS + 8;

  // Every accepted word comes back after the fixed pipeline depth.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching start");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_rx == '0 && out_ry == '0 && out_rz == '0 &&
       out_length_out == '0 && !out_saturated))
    else $error("zero-length result carries nonzero fields");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy asserted");
endmodule

bind vector3_alu v3a_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS(FRAC_BITS)
) u_v3a_checker (.*);
`default_nettype wire

// File: test/vector3_alu_tb.sv
// ---------------------------------------------------------------------------
// vector3_alu_tb
// Self-checking bench for the vector ALU. Each word sent is run through a
// fixed-point model of add, subtract, scale, length and normalize, and the
// result word that comes out is compared field by field, in order.
// ---------------------------------------------------------------------------
`default_nettype none
module vector3_alu_tb;
  import v3a_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = CW + FB + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
    logic [CW-1:0]        len;
    logic                 sat;
    logic                 zero;
  } vec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [CW-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [CW-1:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic signed [CW-1:0] in_scale_factor = '0;
  logic out_valid;
  logic signed [CW-1:0] out_rx, out_ry, out_rz;
  logic [CW-1:0] out_length_out;
  logic out_saturated, out_zero_length;

  vec_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int words_sent = 0;
  int results_seen = 0;
  bit gaps_on = 1'b1;

  always #2 clk = ~clk;

  vector3_alu #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_scale_factor(in_scale_factor),
    .out_valid(out_valid), .out_rx(out_rx), .out_ry(out_ry), .out_rz(out_rz),
    .out_length_out(out_length_out), .out_saturated(out_saturated),
    .out_zero_length(out_zero_length)
  );

  // Clamp a sign and magnitude pair to the signed coordinate range.
  function automatic logic [CW-1:0] clamp_mag(input bit neg, input logic [127:0] m,
                                              inout bit sat);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (CW-1)) : ((128'd1 << (CW-1)) - 1);
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? CW'(-m) : CW'(m);
  endfunction

  function automatic logic [CW-1:0] clamp_sum(input logic signed [63:0] s, inout bit sat);
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      s = 64'sd2147483647;
    end else if (s < -64'sd2147483648) begin
      sat = 1'b1;
      s = -64'sd2147483648;
    end
    return s[CW-1:0];
  endfunction

  function automatic logic [63:0] rounded_root(input logic [127:0] n);
    logic [63:0] s, t;
    s = 0;
    for (int b = 52; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (128'(t) * 128'(t) <= n) s = t;
    end
    if (n > 128'(s) * 128'(s) + 128'(s)) s++;
    return s;
  endfunction

  function automatic vec_result_t vector_op(input logic [FUNC_W-1:0] f,
      input logic signed [CW-1:0] a[3], input logic signed [CW-1:0] b[3],
      input logic signed [CW-1:0] k);
    vec_result_t r;
    bit sat;
    logic [CW-1:0] v[3];
    logic [127:0] p, n, q, num, rem;
    logic [63:0] ma, mk, l;
    sat = 0;
    r = '0;
    v[0] = '0; v[1] = '0; v[2] = '0;
    if (f == FUNC_ADD || f == FUNC_SUB) begin
      for (int i = 0; i < 3; i++)
        v[i] = clamp_sum(f == FUNC_ADD ? 64'(a[i]) + 64'(b[i]) : 64'(a[i]) - 64'(b[i]), sat);
    end else if (f == FUNC_SCL) begin
      mk = k < 0 ? 64'(-64'(k)) : 64'(k);
      for (int i = 0; i < 3; i++) begin
        ma = a[i] < 0 ? 64'(-64'(a[i])) : 64'(a[i]);
        p = (128'(ma) * 128'(mk) + (128'd1 << (FB-1))) >> FB;
        v[i] = clamp_mag((a[i] < 0) != (k < 0), p, sat);
      end
    end else if (f == FUNC_LEN || f == FUNC_NORM) begin
      n = 0;
      for (int i = 0; i < 3; i++) begin
        ma = a[i] < 0 ? 64'(-64'(a[i])) : 64'(a[i]);
        n += 128'(ma) * 128'(ma);
      end
      l = rounded_root(n);
      if (l > 64'hFFFF_FFFF) begin
        r.len = '1;
        sat = 1'b1;
      end else r.len = l[CW-1:0];
      if (f == FUNC_NORM) begin
        if (l == 0) r.zero = 1'b1;
        else for (int i = 0; i < 3; i++) begin
          ma = a[i] < 0 ? 64'(-64'(a[i])) : 64'(a[i]);
          num = 128'(ma) << FB;
          q = num / 128'(l);
          rem = num % 128'(l);
          if (rem >= 128'(l) - rem) q++;
          v[i] = clamp_mag(a[i] < 0, q, sat);
        end
      end
    end
    r.rx = v[0]; r.ry = v[1]; r.rz = v[2];
    r.sat = sat;
    return r;
  endfunction

  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CW-1:0] ax,
      input logic [CW-1:0] ay, input logic [CW-1:0] az, input logic [CW-1:0] bx,
      input logic [CW-1:0] by, input logic [CW-1:0] bz, input logic [CW-1:0] k);
    logic signed [CW-1:0] a[3], b[3];
    int gap;
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    start <= 1'b1;
    in_func <= f;
    in_ax <= ax; in_ay <= ay; in_az <= az;
    in_bx <= bx; in_by <= by; in_bz <= bz;
    in_scale_factor <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(vector_op(f, a, b, k));
    words_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic idle_start;
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained;
    idle_start();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rnd_coord(input int range_sel);
    case (range_sel)
      0: return $urandom();
      1: return CW'($signed($urandom_range(0, 16'hFFFF)) - 32'sd32768);
      2: return CW'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sd8388608);
      3: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ $urandom_range(0, 3);
      default: return '0;
    endcase
  endfunction

  task automatic test_extremes;
    logic [CW-1:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_word(FUNC_ADD, mx, mn, 0, mx, mn, 0, 0);
    send_word(FUNC_ADD, mx, mn, 1, mn, mx, 32'hFFFF_FFFF, 0);
    send_word(FUNC_SUB, mx, mn, 0, mn, mx, 0, 0);
    send_word(FUNC_SUB, 0, mn, mx, mn, 1, 32'hFFFF_FFFF, 0);
    send_word(FUNC_SCL, mx, mn, 32'h0001_0000, 0, 0, 0, mx);
    send_word(FUNC_SCL, mx, mn, 32'h0001_0000, 0, 0, 0, mn);
    send_word(FUNC_SCL, 32'h0000_8000, 32'hFFFF_8000, 1, 0, 0, 0, 32'h0000_0001);
    send_word(FUNC_SCL, 32'h0001_0000, 32'hFFFF_0000, 3, 0, 0, 0, 32'h0000_8000);
    send_word(FUNC_LEN, mx, mn, mn, mx, mx, mx, mx);
    send_word(FUNC_LEN, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0);
    send_word(FUNC_LEN, 0, 0, 0, 0, 0, 0, 0);
    send_word(FUNC_NORM, 0, 0, 0, mx, mx, mx, mx);
    send_word(FUNC_NORM, mx, mn, mn, 0, 0, 0, 0);
    send_word(FUNC_NORM, 1, 0, 0, 0, 0, 0, 0);
    send_word(FUNC_NORM, 32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0);
    send_word(FUNC_NORM, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0, 0, 0);
    for (int f = 5; f < 8; f++) send_word(FUNC_W'(f), mx, mn, 1, mx, mn, 1, mx);
  endtask

  task automatic test_random(input int count);
    logic [FUNC_W-1:0] f;
    int rs;
    for (int i = 0; i < count; i++) begin
      f = ($urandom_range(0, 15) == 0) ? FUNC_W'($urandom_range(5, 7))
                                       : FUNC_W'($urandom_range(0, 4));
      rs = $urandom_range(0, 4);
      send_word(f, rnd_coord(rs), rnd_coord(rs), rnd_coord(rs), rnd_coord(rs),
                rnd_coord(rs), rnd_coord(rs), rnd_coord($urandom_range(0, 4)));
    end
  endtask

  // Results cannot be held off, so every strobe is checked at the edge.
  always @(posedge clk) begin
    vec_result_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      got = '{out_rx, out_ry, out_rz, out_length_out, out_saturated, out_zero_length};
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    wait_drained();
    test_random(700);
    wait_drained();
    test_random(550);
    gaps_on = 1'b0;
    test_random(100);
    idle_start();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d words over all five operations and unknown codes; %0d results checked.",
             words_sent, results_seen);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
sv/v3a_pkg.sv
sv/v3a_front_lane.sv
sv/v3a_sqrt.sv
sv/v3a_div.sv
sv/vector3_alu.sv
sv/v3a_checker.sv
test/vector3_alu_tb.sv
